FILE: hw/rtl/tss_pkg.sv
// ============================================================================
// tss_pkg: shared types and constants of the triggered smoothstep slew
// Holds the fixed-point widths, the microcode word layout and the control
// store that sequences the single multiply and round datapath.
// ============================================================================
package tss_pkg;

	// Fixed-point widths and constants.
	localparam int PHASE_W     = 25;
	localparam int SAMPLE_W    = 16;
	localparam int SPAN_W      = 17;
	localparam int COEF_W      = 16;
	localparam int STEP_CFG_W  = 25;
	localparam int OPND_W      = 30;
	localparam int PROD_W      = 2 * OPND_W;
	localparam int FRAC_W      = 24;
	localparam int RND_W       = PROD_W - FRAC_W;
	localparam int VAL_W       = 23;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 25;

	localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << FRAC_W;
	localparam logic [PROD_W-1:0]  HALF_LSB   = PROD_W'(1) << (FRAC_W - 1);
	localparam logic [COEF_W-1:0]  COEF_THREE = COEF_W'(24576);
	localparam logic [STEP_CFG_W-1:0] STEP_RESET = STEP_CFG_W'(350);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_CURVE_COEF = CFG_INDEX_W'(1);

	// Program counter and the addresses that jumps land on.
	localparam int STEP_W = 5;
	localparam int UC_LEN = 18;
	localparam logic [STEP_W-1:0] UC_IDLE    = STEP_W'(0);
	localparam logic [STEP_W-1:0] UC_CUR_TGT = STEP_W'(7);
	localparam logic [STEP_W-1:0] UC_SET     = STEP_W'(8);
	localparam logic [STEP_W-1:0] UC_ADV     = STEP_W'(9);
	localparam logic [STEP_W-1:0] UC_NEW_TGT = STEP_W'(16);
	localparam logic [STEP_W-1:0] UC_EMIT    = STEP_W'(17);

	// Multiplier operand selection.
	typedef enum logic [1:0] {
		MUL_NONE = 2'd0,
		MUL_PP   = 2'd1,
		MUL_P2D  = 2'd2,
		MUL_ST   = 2'd3
	} mul_op_t;

	// Destination of the rounded product.
	typedef enum logic [1:0] {
		RND_NONE = 2'd0,
		RND_P2   = 2'd1,
		RND_T    = 2'd2,
		RND_V    = 2'd3
	} rnd_op_t;

	// Sequencing of the program counter.
	typedef enum logic [2:0] {
		JMP_NEXT   = 3'd0,
		JMP_ALWAYS = 3'd1,
		JMP_DONE   = 3'd2,
		JMP_INPUT  = 3'd3,
		JMP_OUTPUT = 3'd4
	} jmp_t;

	// One control word.
	typedef struct packed {
		mul_op_t           mul_op;
		rnd_op_t           rnd_op;
		logic              coef_three;
		logic              load_target;
		logic              set_glide;
		logic              advance;
		jmp_t              jmp;
		logic [STEP_W-1:0] jmp_to;
	} ucode_t;

	// Control store. The first half evaluates the current value with the
	// smoothstep coefficient on a trigger, the second half advances the
	// phase and evaluates the output with the configured coefficient.
	function automatic ucode_t uc_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			5'd0: w = '{MUL_NONE, RND_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_INPUT, UC_ADV};
			5'd1: w = '{MUL_PP, RND_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_DONE, UC_CUR_TGT};
			5'd2: w = '{MUL_NONE, RND_P2, 1'b1, 1'b0, 1'b0, 1'b0, JMP_NEXT, UC_IDLE};
			5'd3: w = '{MUL_P2D, RND_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, UC_IDLE};
			5'd4: w = '{MUL_NONE, RND_T, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, UC_IDLE};
			5'd5: w = '{MUL_ST, RND_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, UC_IDLE};
			5'd6: w = '{MUL_NONE, RND_V, 1'b0, 1'b0, 1'b0, 1'b0, JMP_ALWAYS, UC_SET};
			5'd7: w = '{MUL_NONE, RND_NONE, 1'b0, 1'b1, 1'b0, 1'b0, JMP_NEXT, UC_IDLE};
			5'd8: w = '{MUL_NONE, RND_NONE, 1'b0, 1'b0, 1'b1, 1'b0, JMP_NEXT, UC_IDLE};
			5'd9: w = '{MUL_NONE, RND_NONE, 1'b0, 1'b0, 1'b0, 1'b1, JMP_DONE, UC_NEW_TGT};
			5'd10: w = '{MUL_PP, RND_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, UC_IDLE};
			5'd11: w = '{MUL_NONE, RND_P2, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, UC_IDLE};
			5'd12: w = '{MUL_P2D, RND_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, UC_IDLE};
			5'd13: w = '{MUL_NONE, RND_T, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, UC_IDLE};
			5'd14: w = '{MUL_ST, RND_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, UC_IDLE};
			5'd15: w = '{MUL_NONE, RND_V, 1'b0, 1'b0, 1'b0, 1'b0, JMP_ALWAYS, UC_EMIT};
			5'd16: w = '{MUL_NONE, RND_NONE, 1'b0, 1'b1, 1'b0, 1'b0, JMP_NEXT, UC_IDLE};
			5'd17: w = '{MUL_NONE, RND_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_OUTPUT, UC_IDLE};
			default: w = '{MUL_NONE, RND_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_ALWAYS, UC_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: hw/rtl/triggered_smoothstep_slew.sv
// ============================================================================
// triggered_smoothstep_slew: cubic glide from a frozen start to a new target
// A microcoded sequencer steps one shared multiplier and one rounding stage
// through the fixed-point evaluation of start + span * p*p*(c - 2p).
// ============================================================================

// Each accepted beat is one sample tick and yields exactly one output beat.
// A beat without trigger takes a longer path from acceptance to the output
// register while a glide is in progress than once the phase has reached
// one; a triggered beat takes longer still, the longer way when the current
// value must itself be interpolated before the new glide starts.
// The path is set by the microcode program, which runs every multiply and
// every rounding through the single 30 by 30 bit multiplier and the rounding
// stage behind it, one operation per cycle. A new input beat is taken as soon
// as the result of the previous one has moved to the output register, even
// while that result still waits to be taken.
module triggered_smoothstep_slew (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [tss_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tss_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tss_pkg::SAMPLE_W-1:0]     new_sample,
	input  logic                             trigger,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tss_pkg::SAMPLE_W-1:0]     smoothed_value
);
	import tss_pkg::*;

	// Configuration registers.
	logic [STEP_CFG_W-1:0] phase_step_q;
	logic [COEF_W-1:0]     curve_coef_q;

	// Architectural state.
	logic [PHASE_W-1:0]        phase_q;
	logic [SAMPLE_W-1:0]       start_q;
	logic [SAMPLE_W-1:0]       target_q;
	logic signed [SPAN_W-1:0]  span_q;

	// Sequencer and datapath registers.
	logic [STEP_W-1:0]         step_q;
	logic [STEP_W-1:0]         step_next;
	logic [SAMPLE_W-1:0]       sample_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [PHASE_W-1:0]        p2_q;
	logic signed [OPND_W-1:0]  d_q;
	logic signed [OPND_W-1:0]  t_q;
	logic [SAMPLE_W-1:0]       val_q;
	logic                      out_valid_q;
	logic [SAMPLE_W-1:0]       smoothed_value_q;

	// Combinational signals.
	ucode_t                    uc;
	logic                      phase_done;
	logic                      out_free;
	logic signed [OPND_W-1:0]  op_a;
	logic signed [OPND_W-1:0]  op_b;
	logic [COEF_W-1:0]         coef_sel;
	logic signed [OPND_W-1:0]  d_next;
	logic [PHASE_W-1:0]        step_eff;
	logic [PHASE_W:0]          phase_sum;
	logic [PHASE_W-1:0]        phase_adv;
	logic [PROD_W-1:0]         prod_mag;
	logic [PROD_W-1:0]         prod_rsum;
	logic signed [RND_W-1:0]   rnd_mag;
	logic signed [RND_W-1:0]   rnd;
	logic signed [VAL_W-1:0]   val_sum;
	logic [SAMPLE_W-1:0]       val_sat;
	logic signed [SPAN_W-1:0]  span_next;

	// Control word decode and handshake.
	always_comb begin
		uc         = uc_rom(step_q);
		phase_done = (phase_q >= PHASE_ONE);
		out_free   = !out_valid_q || out_ready;
		in_ready   = (uc.jmp == JMP_INPUT);
	end

	// Program counter sequencing.
	always_comb begin
		case (uc.jmp)
			JMP_NEXT:   step_next = step_q + STEP_W'(1);
			JMP_ALWAYS: step_next = uc.jmp_to;
			JMP_DONE:   step_next = phase_done ? uc.jmp_to : step_q + STEP_W'(1);
			JMP_INPUT: begin
				if (!in_valid)
					step_next = step_q;
				else if (trigger)
					step_next = step_q + STEP_W'(1);
				else
					step_next = uc.jmp_to;
			end
			JMP_OUTPUT: step_next = out_free ? uc.jmp_to : step_q;
			default:    step_next = UC_IDLE;
		endcase
	end

	// Multiplier operand selection.
	always_comb begin
		case (uc.mul_op)
			MUL_PP: begin
				op_a = $signed({{(OPND_W-PHASE_W){1'b0}}, phase_q});
				op_b = $signed({{(OPND_W-PHASE_W){1'b0}}, phase_q});
			end
			MUL_P2D: begin
				op_a = $signed({{(OPND_W-PHASE_W){1'b0}}, p2_q});
				op_b = d_q;
			end
			MUL_ST: begin
				op_a = {{(OPND_W-SPAN_W){span_q[SPAN_W-1]}}, span_q};
				op_b = t_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Cubic term offset c * 2^11 - 2p, formed ahead of its multiply.
	always_comb begin
		coef_sel = uc.coef_three ? COEF_THREE : curve_coef_q;
		d_next   = $signed({3'b000, coef_sel, 11'b0})
			- $signed({4'b0000, phase_q, 1'b0});
	end

	// Round the product to nearest at 2^-24, halves away from zero.
	always_comb begin
		prod_mag  = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		prod_rsum = prod_mag + HALF_LSB;
		rnd_mag   = $signed(prod_rsum[PROD_W-1:FRAC_W]);
		rnd       = prod_q[PROD_W-1] ? -rnd_mag : rnd_mag;
	end

	// Add the scaled span to the start point and saturate to 16 bits.
	always_comb begin
		val_sum = $signed({{(VAL_W-SAMPLE_W){1'b0}}, start_q}) + rnd[VAL_W-1:0];
		if (val_sum < 0)
			val_sat = '0;
		else if (val_sum > $signed({{(VAL_W-SAMPLE_W){1'b0}}, {SAMPLE_W{1'b1}}}))
			val_sat = '1;
		else
			val_sat = val_sum[SAMPLE_W-1:0];
	end

	// Phase advance, with the step and the result both clamped at one.
	always_comb begin
		step_eff  = (phase_step_q > PHASE_ONE) ? PHASE_ONE : phase_step_q;
		phase_sum = {1'b0, phase_q} + {1'b0, step_eff};
		phase_adv = (phase_sum > {1'b0, PHASE_ONE}) ? PHASE_ONE : phase_sum[PHASE_W-1:0];
		span_next = $signed({1'b0, sample_q}) - $signed({1'b0, val_q});
	end

	// Control state, configuration and glide state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= UC_IDLE;
			out_valid_q  <= 1'b0;
			phase_step_q <= STEP_RESET;
			curve_coef_q <= COEF_THREE;
			phase_q      <= PHASE_ONE;
			start_q      <= '0;
			target_q     <= '0;
			span_q       <= '0;
		end else begin
			step_q <= step_next;
			if (cfg_write) begin
				case (cfg_index)
					REG_PHASE_STEP: phase_step_q <= cfg_data[STEP_CFG_W-1:0];
					REG_CURVE_COEF: curve_coef_q <= cfg_data[COEF_W-1:0];
					default: ;
				endcase
			end
			if (uc.jmp == JMP_OUTPUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (uc.set_glide) begin
				start_q  <= val_q;
				target_q <= sample_q;
				span_q   <= span_next;
				phase_q  <= '0;
			end else if (uc.advance && !phase_done) begin
				phase_q <= phase_adv;
			end
		end
	end

	// Datapath payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			sample_q <= new_sample;
		if (uc.mul_op != MUL_NONE)
			prod_q <= op_a * op_b;
		case (uc.rnd_op)
			RND_P2: begin
				p2_q <= rnd[PHASE_W-1:0];
				d_q  <= d_next;
			end
			RND_T:  t_q   <= rnd[OPND_W-1:0];
			RND_V:  val_q <= val_sat;
			default: ;
		endcase
		if (uc.load_target)
			val_q <= target_q;
		if (uc.jmp == JMP_OUTPUT && out_free)
			smoothed_value_q <= val_q;
	end

	assign out_valid      = out_valid_q;
	assign smoothed_value = smoothed_value_q;

	// The phase never passes one.
	assert property (@(posedge clk) disable iff (!arst_n) phase_q <= PHASE_ONE)
		else $error("phase passed one");

	// The program counter stays inside the control store.
	assert property (@(posedge clk) disable iff (!arst_n) step_q < STEP_W'(UC_LEN))
		else $error("program counter outside the control store");

	// An accepted beat is not followed by another until its result is made.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted twice in a row");

	// A result appears only from the emit step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step_q) == UC_EMIT)
		else $error("output raised outside the emit step");

endmodule
